FILE: design/pairwise_fst_wc84_accumulator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pairwise Fst accumulator
// Immediate-consequence and next-cycle forms, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_FST_WC84_ACCUMULATOR_CORE_ASSERT_SVH
`define PAIRWISE_FST_WC84_ACCUMULATOR_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PFST_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfst assertion failed");

// antecedent implies consequent in the next cycle
`define PFST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfst assertion failed");

`endif

FILE: design/pfst_pkg.sv
// ----------------------------------------------------------------------------
// pfst_pkg
// Shared constants, types and saturation helpers of the pairwise Fst block.
// ----------------------------------------------------------------------------
package pfst_pkg;

   localparam int COUNT_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int IFRAC      = 28;
   localparam int FSHIFT     = IFRAC - FRAC_BITS;

   localparam logic [63:0] ONE_Q   = 64'd1 << IFRAC;
   localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic signed [63:0] MAX40 = 64'sh0000_007F_FFFF_FFFF;
   localparam logic signed [63:0] MIN40 = -MAX40 - 64'sd1;
   localparam logic signed [63:0] MAX56 = 64'sh007F_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN56 = -MAX56 - 64'sd1;
   localparam logic [63:0] LIM40 = 64'h0000_0080_0000_0000;
   localparam logic [63:0] LIM32 = 64'h0000_0000_8000_0000;

   // register indexes
   localparam logic CSR_PER_LOCUS = 1'b0;
   localparam logic CSR_SPLIT     = 1'b1;

   // request to the shared multiply-divide unit
   typedef struct packed {
      logic        start;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] d;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } md_rsp_type;

   // sequencer operations, in issue order
   typedef enum logic [4:0] {
      OP_PA, OP_PB, OP_PBAR, OP_HA, OP_HB, OP_HBAR, OP_SQ, OP_S2A, OP_S2B,
      OP_PQ, OP_U, OP_A1, OP_A2, OP_HT, OP_B, OP_RL, OP_RT
   } op_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      mag64 = v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
      if (v > MAX40) sat40 = MAX40[39:0];
      else if (v < MIN40) sat40 = MIN40[39:0];
      else sat40 = v[39:0];
   endfunction

   function automatic logic signed [55:0] sat56(input logic signed [63:0] v);
      if (v > MAX56) sat56 = MAX56[55:0];
      else if (v < MIN56) sat56 = MIN56[55:0];
      else sat56 = v[55:0];
   endfunction

   // signed quotient from magnitude, saturated to 40 bits
   function automatic logic signed [39:0] ratio40(input logic [63:0] q, input logic neg);
      logic [63:0] nq;
      nq = -q;
      if (!neg) ratio40 = (q >= LIM40) ? MAX40[39:0] : q[39:0];
      else ratio40 = (q > LIM40) ? MIN40[39:0] : nq[39:0];
   endfunction

   function automatic logic signed [31:0] ratio32(input logic [63:0] q, input logic neg);
      logic [63:0] nq;
      nq = -q;
      if (!neg) ratio32 = (q >= LIM32) ? 32'sh7FFF_FFFF : q[31:0];
      else ratio32 = (q > LIM32) ? 32'sh8000_0000 : nq[31:0];
   endfunction

endpackage

FILE: design/pfst_muldiv.sv
// ----------------------------------------------------------------------------
// pfst_muldiv
// Shared unit: floor(x*y/d) saturated to 2^63-1, one bit per cycle
// (shift-add multiply, then restoring divide).
// ----------------------------------------------------------------------------
module pfst_muldiv
   import pfst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type req,
   output md_rsp_type rsp
);

   typedef enum logic [2:0] {
      MD_IDLE = 3'b001,
      MD_MUL  = 3'b010,
      MD_DIV  = 3'b100
   } md_state_type;

   md_state_type state_ff, state_in;
   logic [63:0]  x_ff, x_in, y_ff, y_in, d_ff, d_in;
   logic [127:0] prod_ff, prod_in;
   logic [63:0]  rem_ff, rem_in, q_ff, q_in, res_ff, res_in;
   logic         ovf_ff, ovf_in, done_ff, done_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63:0]  rsh;
   logic         take, ovf_all;

   // one divide step
   always_comb begin
      rsh     = {rem_ff[62:0], prod_ff[127]};
      take    = rem_ff[63] || (rsh >= d_ff);
      ovf_all = ovf_ff | q_ff[63];
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (req.start) begin
               x_in    = req.x;
               y_in    = req.y;
               d_in    = req.d;
               prod_in = '0;
               rem_in  = '0;
               q_in    = '0;
               ovf_in  = 1'b0;
               cnt_in  = 7'd63;
               if (req.d == '0) begin
                  // zero divisor: saturate unless the product is zero
                  res_in  = (req.x == '0 || req.y == '0) ? '0 : MAG_MAX;
                  done_in = 1'b1;
               end else begin
                  state_in = MD_MUL;
               end
            end
         end
         MD_MUL: begin
            prod_in = (prod_ff << 1) + (y_ff[63] ? {64'd0, x_ff} : 128'd0);
            y_in    = y_ff << 1;
            if (cnt_ff == '0) begin
               cnt_in   = 7'd127;
               state_in = MD_DIV;
            end else begin
               cnt_in = cnt_ff - 7'd1;
            end
         end
         MD_DIV: begin
            prod_in = prod_ff << 1;
            rem_in  = take ? (rsh - d_ff) : rsh;
            q_in    = {q_ff[62:0], take};
            ovf_in  = ovf_all;
            if (cnt_ff == '0) begin
               res_in   = (ovf_all || q_ff[62]) ? MAG_MAX : {q_ff[62:0], take};
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end else begin
               cnt_in = cnt_ff - 7'd1;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.q    = res_ff;

endmodule

FILE: design/pairwise_fst_wc84_accumulator_core.sv
// Work: a defined locus takes 15 to 16 unit operations, plus one more operation on a
// last locus whose denominator sum is nonzero; an undefined locus takes only that one,
// if any. Throughput: one item at a time, set by the single bit-serial
// multiply-divide unit. Reset: sums cleared, per_locus_results 1, split_num_den 0.
// ----------------------------------------------------------------------------
// pairwise_fst_wc84_accumulator_core
// Weir-Cockerham Fst for one population pair: variance components per locus
// through a shared multiply-divide unit, running sums and a total on last locus.
// ----------------------------------------------------------------------------
module pairwise_fst_wc84_accumulator_core
   import pfst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_count_a,
   input  logic [15:0]        req_count_b,
   input  logic [16:0]        req_freq_a,
   input  logic [16:0]        req_freq_b,
   input  logic [16:0]        req_het_a,
   input  logic [16:0]        req_het_b,
   input  logic               req_last_locus,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [39:0] rsp_locus_first,
   output logic signed [39:0] rsp_locus_second,
   output logic               rsp_locus_valid,
   output logic signed [31:0] rsp_total_fst,
   output logic               rsp_total_valid,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [0:0]         csr_wdata
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ISSUE = 7'b0000010,
      ST_WAIT  = 7'b0000100,
      ST_DEN   = 7'b0001000,
      ST_SUM   = 7'b0010000,
      ST_TOT   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic                    per_locus_ff, split_ff;
   logic [COUNT_BITS-1:0]   ca_ff, ca_in, cb_ff, cb_in;
   logic [COUNT_BITS:0]     t_ff, t_in;
   logic [FRAC_BITS:0]      pa_ff, pa_in, pb_ff, pb_in, ha_ff, ha_in, hb_ff, hb_in;
   logic                    last_ff, last_in;
   logic [63:0]             acc_ff, acc_in, pbar_ff, pbar_in, hbar_ff, hbar_in;
   logic [63:0]             s2_ff, s2_in;
   logic signed [63:0]      pq_ff, pq_in;
   logic signed [39:0]      a_ff, a_in, b_ff, b_in, den_ff, den_in;
   logic signed [55:0]      nsum_ff, nsum_in, dsum_ff, dsum_in;
   logic signed [39:0]      first_ff, first_in, second_ff, second_in;
   logic                    lvalid_ff, lvalid_in, tvalid_ff, tvalid_in;
   logic signed [31:0]      total_ff, total_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [39:0]      rsp_first_ff, rsp_first_in, rsp_second_ff, rsp_second_in;
   logic                    rsp_lvalid_ff, rsp_lvalid_in;
   logic signed [31:0]      rsp_total_ff, rsp_total_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in, rsp_last_ff, rsp_last_in;

   md_req_type              md_req;
   md_rsp_type              md_rsp;

   logic [63:0]             ca64, cb64, t64, pa64, pb64, ha64, hb64, dm;
   logic signed [63:0]      one_m_pbar, u_s, v_s, a_ext, b_ext, den_ext;
   logic signed [63:0]      nsum_ext, dsum_ext, res_s, acc_s;
   logic [63:0]             md_x, md_y, md_d;
   logic                    op_neg, accept, locus_ok;
   logic [COUNT_BITS:0]     t_req;

   // ---- operand forming ----
   always_comb begin
      ca64       = 64'(ca_ff);
      cb64       = 64'(cb_ff);
      t64        = 64'(t_ff);
      pa64       = 64'(pa_ff) << FSHIFT;
      pb64       = 64'(pb_ff) << FSHIFT;
      ha64       = 64'(ha_ff) << FSHIFT;
      hb64       = 64'(hb_ff) << FSHIFT;
      dm         = (pa64 >= pb64) ? (pa64 - pb64) : (pb64 - pa64);
      one_m_pbar = $signed(ONE_Q - pbar_ff);
      u_s        = pq_ff - $signed(s2_ff >> 1) - $signed(hbar_ff >> 2);
      v_s        = pq_ff - $signed(s2_ff >> 1) - $signed(acc_ff);
      acc_s      = $signed(acc_ff);
      a_ext      = 64'(a_ff);
      b_ext      = 64'(b_ff);
      den_ext    = 64'(den_ff);
      nsum_ext   = 64'(nsum_ff);
      dsum_ext   = 64'(dsum_ff);
   end

   // ---- operand select per operation ----
   always_comb begin
      md_x   = '0;
      md_y   = 64'd1;
      md_d   = 64'd1;
      op_neg = 1'b0;
      case (op_ff)
         OP_PA:   begin md_x = pa64; md_y = ca64; end
         OP_PB:   begin md_x = pb64; md_y = cb64; end
         OP_PBAR: begin md_x = acc_ff; md_d = t64; end
         OP_HA:   begin md_x = ha64; md_y = ca64; end
         OP_HB:   begin md_x = hb64; md_y = cb64; end
         OP_HBAR: begin md_x = acc_ff; md_d = t64; end
         OP_SQ:   begin md_x = dm; md_y = dm; end
         OP_S2A:  begin md_x = acc_ff; md_y = ca64 << 1; md_d = t64; end
         OP_S2B:  begin md_x = acc_ff; md_y = cb64; md_d = t64; end
         OP_PQ: begin
            md_x = mag64(one_m_pbar); md_y = pbar_ff; md_d = ONE_Q;
            op_neg = one_m_pbar[63];
         end
         OP_U: begin
            md_x = mag64(u_s); md_y = 64'd4; md_d = t64 - 64'd4; op_neg = u_s[63];
         end
         OP_A1: begin
            md_x = mag64(acc_s); md_y = t64; md_d = cb64 << 2; op_neg = acc_s[63];
         end
         OP_A2: begin
            md_x = mag64(acc_s); md_y = t64; md_d = ca64; op_neg = acc_s[63];
         end
         OP_HT: begin md_x = hbar_ff; md_y = t64 - 64'd2; md_d = t64 << 1; end
         OP_B: begin
            md_x = mag64(v_s); md_y = t64; md_d = t64 - 64'd4; op_neg = v_s[63];
         end
         OP_RL: begin
            md_x = mag64(a_ext); md_y = ONE_Q; md_d = mag64(den_ext);
            op_neg = a_ff[39] ^ den_ff[39];
         end
         OP_RT: begin
            md_x = mag64(nsum_ext); md_y = ONE_Q; md_d = mag64(dsum_ext);
            op_neg = nsum_ff[55] ^ dsum_ff[55];
         end
         default: md_x = '0;
      endcase
   end

   assign md_req.start = (state_ff == ST_ISSUE);
   assign md_req.x     = md_x;
   assign md_req.y     = md_y;
   assign md_req.d     = md_d;

   pfst_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   assign res_s   = op_neg ? $signed(-md_rsp.q) : $signed(md_rsp.q);
   assign accept  = req_valid && req_ready;
   assign t_req   = {1'b0, req_count_a[COUNT_BITS-1:0]} + {1'b0, req_count_b[COUNT_BITS-1:0]};
   assign locus_ok = (req_count_a[COUNT_BITS-1:0] != '0) && (req_count_b[COUNT_BITS-1:0] != '0)
                     && (t_req > (COUNT_BITS+1)'(4));

   // ---- sequencer ----
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      ca_in     = ca_ff;
      cb_in     = cb_ff;
      t_in      = t_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      ha_in     = ha_ff;
      hb_in     = hb_ff;
      last_in   = last_ff;
      acc_in    = acc_ff;
      pbar_in   = pbar_ff;
      hbar_in   = hbar_ff;
      s2_in     = s2_ff;
      pq_in     = pq_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      den_in    = den_ff;
      nsum_in   = nsum_ff;
      dsum_in   = dsum_ff;
      first_in  = first_ff;
      second_in = second_ff;
      lvalid_in = lvalid_ff;
      total_in  = total_ff;
      tvalid_in = tvalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_lvalid_in = rsp_lvalid_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ca_in     = req_count_a[COUNT_BITS-1:0];
               cb_in     = req_count_b[COUNT_BITS-1:0];
               t_in      = t_req;
               pa_in     = req_freq_a[FRAC_BITS:0];
               pb_in     = req_freq_b[FRAC_BITS:0];
               ha_in     = req_het_a[FRAC_BITS:0];
               hb_in     = req_het_b[FRAC_BITS:0];
               last_in   = req_last_locus;
               first_in  = '0;
               second_in = '0;
               lvalid_in = 1'b0;
               total_in  = '0;
               tvalid_in = 1'b0;
               op_in     = OP_PA;
               state_in  = locus_ok ? ST_ISSUE : ST_TOT;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (md_rsp.done) begin
               state_in = ST_ISSUE;
               case (op_ff)
                  OP_PA:   begin acc_in = md_rsp.q; op_in = OP_PB; end
                  OP_PB:   begin acc_in = acc_ff + md_rsp.q; op_in = OP_PBAR; end
                  OP_PBAR: begin pbar_in = md_rsp.q; op_in = OP_HA; end
                  OP_HA:   begin acc_in = md_rsp.q; op_in = OP_HB; end
                  OP_HB:   begin acc_in = acc_ff + md_rsp.q; op_in = OP_HBAR; end
                  OP_HBAR: begin hbar_in = md_rsp.q; op_in = OP_SQ; end
                  OP_SQ:   begin acc_in = md_rsp.q; op_in = OP_S2A; end
                  OP_S2A:  begin acc_in = md_rsp.q; op_in = OP_S2B; end
                  OP_S2B:  begin s2_in = md_rsp.q >> IFRAC; op_in = OP_PQ; end
                  OP_PQ:   begin pq_in = res_s; op_in = OP_U; end
                  OP_U:    begin acc_in = 64'($signed(s2_ff) - res_s); op_in = OP_A1; end
                  OP_A1:   begin acc_in = 64'(res_s); op_in = OP_A2; end
                  OP_A2:   begin a_in = sat40(res_s); op_in = OP_HT; end
                  OP_HT:   begin acc_in = md_rsp.q; op_in = OP_B; end
                  OP_B: begin
                     b_in     = sat40(res_s);
                     state_in = ST_DEN;
                  end
                  OP_RL: begin
                     first_in = ratio40(md_rsp.q, op_neg);
                     state_in = ST_TOT;
                  end
                  OP_RT: begin
                     total_in  = ratio32(md_rsp.q, op_neg);
                     tvalid_in = 1'b1;
                     nsum_in   = '0;
                     dsum_in   = '0;
                     state_in  = ST_DONE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         // denominator a+b+c and numerator sum
         ST_DEN: begin
            den_in   = sat40(a_ext + b_ext + $signed(hbar_ff >> 1));
            nsum_in  = sat56(nsum_ext + a_ext);
            state_in = ST_SUM;
         end
         // denominator sum and per-locus fields
         ST_SUM: begin
            dsum_in   = sat56(dsum_ext + den_ext);
            lvalid_in = per_locus_ff;
            state_in  = ST_TOT;
            if (per_locus_ff) begin
               if (split_ff) begin
                  first_in  = a_ff;
                  second_in = den_ff;
               end else if (den_ff == '0) begin
                  if (a_ff == '0) first_in = '0;
                  else if (a_ff[39]) first_in = MIN40[39:0];
                  else first_in = MAX40[39:0];
               end else begin
                  op_in    = OP_RL;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_TOT: begin
            state_in = ST_DONE;
            if (last_ff) begin
               if (dsum_ff != '0) begin
                  op_in    = OP_RT;
                  state_in = ST_ISSUE;
               end else begin
                  nsum_in = '0;
                  dsum_in = '0;
               end
            end
         end
         // hand the item to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = first_ff;
               rsp_second_in = second_ff;
               rsp_lvalid_in = lvalid_ff;
               rsp_total_in  = total_ff;
               rsp_tvalid_in = tvalid_ff;
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_PA;
         rsp_valid_ff <= 1'b0;
         per_locus_ff <= 1'b1;
         split_ff     <= 1'b0;
         nsum_ff      <= '0;
         dsum_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         nsum_ff      <= nsum_in;
         dsum_ff      <= dsum_in;
         if (csr_valid && csr_ready) begin
            if (csr_index[0] == CSR_PER_LOCUS) per_locus_ff <= csr_wdata[0];
            else if (csr_index[0] == CSR_SPLIT) split_ff <= csr_wdata[0];
         end
      end
      ca_ff     <= ca_in;
      cb_ff     <= cb_in;
      t_ff      <= t_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      ha_ff     <= ha_in;
      hb_ff     <= hb_in;
      last_ff   <= last_in;
      acc_ff    <= acc_in;
      pbar_ff   <= pbar_in;
      hbar_ff   <= hbar_in;
      s2_ff     <= s2_in;
      pq_ff     <= pq_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      den_ff    <= den_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      lvalid_ff <= lvalid_in;
      total_ff  <= total_in;
      tvalid_ff <= tvalid_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_lvalid_ff <= rsp_lvalid_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_tvalid_ff <= rsp_tvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_locus_first  = rsp_first_ff;
   assign rsp_locus_second = rsp_second_ff;
   assign rsp_locus_valid  = rsp_lvalid_ff;
   assign rsp_total_fst    = rsp_total_ff;
   assign rsp_total_valid  = rsp_tvalid_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

FILE: design/pfst_checker.sv
// ----------------------------------------------------------------------------
// pfst_checker
// Port-level checks of the pairwise Fst accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "pairwise_fst_wc84_accumulator_core_assert.svh"

module pfst_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [39:0] rsp_locus_first,
   input logic signed [39:0] rsp_locus_second,
   input logic               rsp_locus_valid,
   input logic signed [31:0] rsp_total_fst,
   input logic               rsp_total_valid,
   input logic               rsp_last
);

   // a waiting result stays valid and holds its total
   `PFST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_total_fst))
   // the block is busy right after taking an item
   `PFST_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // a total only comes with the last locus
   `PFST_ASSERT_NOW(a_total_on_last, rsp_valid && !rsp_last,
                    !rsp_total_valid && rsp_total_fst == 32'sd0)
   // undefined or suppressed loci carry zero fields
   `PFST_ASSERT_NOW(a_locus_zero, rsp_valid && !rsp_locus_valid,
                    rsp_locus_first == 40'sd0 && rsp_locus_second == 40'sd0)

endmodule

bind pairwise_fst_wc84_accumulator_core pfst_checker u_pfst_checker (.*);
